>>> hw/rtl/ppp_pkg.sv
// ----------------------------------------------------------------------------
// Point projection package
// Shared types, widths, register indexes and field helpers for the closest
// point on box, cylinder and sphere datapath.
// ----------------------------------------------------------------------------
package ppp_pkg;

    // Coordinate and field widths.
    localparam int COORD_W  = 21;   // signed Q5.16 point and origin fields
    localparam int ROT_W    = 16;   // signed Q1.14 rotation entries
    localparam int OFF_W    = 22;   // point minus origin, exact
    localparam int LOC_W    = 26;   // local coordinate after rotation
    localparam int PROD_W   = 38;   // rotation entry times 22-bit value
    localparam int ACC_W    = 40;   // sum of three products
    localparam int RAD_W    = 52;   // squared radial distance
    localparam int ROOT_W   = 26;   // floor square root of RAD_W bits
    localparam int NUM_W    = 47;   // radius times magnitude
    localparam int QUO_W    = 21;   // pulled component magnitude
    localparam int WORLD_W  = 27;   // world coordinate before saturation
    localparam int DATA_W   = 64;   // three coordinates padded to bytes

    // Shared unit depths.
    localparam int SQRT_STEPS = 2;
    localparam int SQRT_LAT   = ROOT_W / SQRT_STEPS;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_LAT    = QUO_W / DIV_STEPS;

    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration register indexes.
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_SHAPE_KIND    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROTATION_ROW0 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROTATION_ROW1 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROTATION_ROW2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_PACKED = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SHAPE_SIZES   = 3'd5;
    localparam int CFG_DATA_W = 63;

    localparam logic [47:0] ROT_ROW0_RST = 48'd16384;
    localparam logic [47:0] ROT_ROW1_RST = 48'd1073741824;
    localparam logic [47:0] ROT_ROW2_RST = 48'd70368744177664;

    // Shape kind codes as written by software.
    localparam logic [1:0] KIND_BOX      = 2'd0;
    localparam logic [1:0] KIND_CYLINDER = 2'd1;
    localparam logic [1:0] KIND_SPHERE   = 2'd2;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    // Class codes attached to each request by the front end.
    localparam logic [1:0] CLS_BOX = 2'd0;
    localparam logic [1:0] CLS_CYL = 2'd1;
    localparam logic [1:0] CLS_SPH = 2'd2;

    typedef struct packed {
        logic [1:0]  shape_kind;
        logic [47:0] rotation_row0;
        logic [47:0] rotation_row1;
        logic [47:0] rotation_row2;
        logic [62:0] origin_packed;
        logic [62:0] shape_sizes;
    } cfg_t;

    typedef struct packed {
        logic [1:0]             cls;
        logic [2:0][OFF_W-1:0]  d;
    } item_t;

    // Rotation entry R[i][j].
    function automatic logic signed [ROT_W-1:0] rot_at(cfg_t c, int i, int j);
        logic [47:0] row;
        row = (i == 0) ? c.rotation_row0 : ((i == 1) ? c.rotation_row1 : c.rotation_row2);
        return row[ROT_W*j +: ROT_W];
    endfunction

    function automatic logic signed [COORD_W-1:0] org_at(cfg_t c, int i);
        return c.origin_packed[COORD_W*i +: COORD_W];
    endfunction

    function automatic logic [COORD_W-1:0] size_at(cfg_t c, int i);
        return c.shape_sizes[COORD_W*i +: COORD_W];
    endfunction

endpackage

>>> hw/rtl/point_projection_onto_primitive_top.sv
// ----------------------------------------------------------------------------
// Point projection onto primitive, top level
// Closest point on a configured box, cylinder or sphere for a stream of
// Q5.16 query points.
// ----------------------------------------------------------------------------
// The block takes one point per clock while it is ready and returns one
// closest point per request, in order. A request passes a front register, a
// short queue and a fully pipelined back end of four rotation and test
// stages, a shared square root of 13 stages, three dividers of 7 stages, and
// three stages for the final local point, the rotation back and saturation.
// The back end advances whenever its output register is free or being taken,
// so a stalled output holds the whole back end while the queue keeps
// accepting requests until it is full. Configuration must be written only
// while the block is idle; the block itself does not enforce this. There is
// no clearing pass after reset.
module point_projection_onto_primitive_top #(
    parameter int QUEUE_DEPTH = ppp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ppp_pkg::DATA_W-1:0]       s_tdata,    // px[20:0], py[41:21], pz[62:42], pad
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ppp_pkg::DATA_W-1:0]       m_tdata,    // qx[20:0], qy[41:21], qz[62:42], pad
    input  logic                             cfg_we,
    input  logic [ppp_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [ppp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ppp_pkg::*;

    cfg_t  cfg_reg;
    logic  fr_valid;
    logic  fr_ready;
    item_t fr_item;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.shape_kind    <= KIND_BOX;
            cfg_reg.rotation_row0 <= ROT_ROW0_RST;
            cfg_reg.rotation_row1 <= ROT_ROW1_RST;
            cfg_reg.rotation_row2 <= ROT_ROW2_RST;
            cfg_reg.origin_packed <= '0;
            cfg_reg.shape_sizes   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SHAPE_KIND:    cfg_reg.shape_kind    <= cfg_wdata[1:0];
                REG_ROTATION_ROW0: cfg_reg.rotation_row0 <= cfg_wdata[47:0];
                REG_ROTATION_ROW1: cfg_reg.rotation_row1 <= cfg_wdata[47:0];
                REG_ROTATION_ROW2: cfg_reg.rotation_row2 <= cfg_wdata[47:0];
                REG_ORIGIN_PACKED: cfg_reg.origin_packed <= cfg_wdata;
                REG_SHAPE_SIZES:   cfg_reg.shape_sizes   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ppp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    ppp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    ppp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (q_valid),
        .in_pop   (q_pop),
        .in_item  (q_item),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_tdata)
    );

endmodule

>>> hw/rtl/ppp_front.sv
// ----------------------------------------------------------------------------
// Point projection front end
// Accepts query points, subtracts the primitive origin and tags each request
// with its shape class.
// ----------------------------------------------------------------------------
module ppp_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ppp_pkg::cfg_t               cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [ppp_pkg::DATA_W-1:0]  s_tdata,   // px, py, pz, zero pad
    output logic                        out_valid,
    input  logic                        out_ready,
    output ppp_pkg::item_t              out_item
);
    import ppp_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    assign s_tready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Offset from the origin and shape class.
    always_comb begin
        logic signed [COORD_W-1:0] p;
        for (int i = 0; i < 3; i++) begin
            p = s_tdata[COORD_W*i +: COORD_W];
            item_next.d[i] = OFF_W'(p) - OFF_W'(org_at(cfg, i));
        end
        unique case (cfg.shape_kind)
            KIND_BOX:                 item_next.cls = CLS_BOX;
            KIND_CYLINDER:            item_next.cls = CLS_CYL;
            KIND_SPHERE, KIND_UNUSED: item_next.cls = CLS_SPH;
            default:                  item_next.cls = CLS_SPH;
        endcase
    end

    // Hold register toward the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_next;
        end
    end

endmodule

>>> hw/rtl/ppp_fifo.sv
// ----------------------------------------------------------------------------
// Point projection request queue
// Short queue that decouples the front end from the projection pipeline.
// ----------------------------------------------------------------------------
module ppp_fifo #(
    parameter int DEPTH = ppp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ppp_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_pop,
    output ppp_pkg::item_t  out_item
);
    import ppp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    // Pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> hw/rtl/ppp_isqrt.sv
// ----------------------------------------------------------------------------
// Point projection square root
// Pipelined digit-by-digit floor square root, two root bits per stage.
// ----------------------------------------------------------------------------
module ppp_isqrt (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [ppp_pkg::RAD_W-1:0]    radicand,
    output logic [ppp_pkg::ROOT_W-1:0]   root
);
    import ppp_pkg::*;

    logic [RAD_W-1:0]  rem_reg  [SQRT_LAT];
    logic [ROOT_W-1:0] root_reg [SQRT_LAT];

    for (genvar s = 0; s < SQRT_LAT; s++) begin : g_stage
        logic [RAD_W-1:0]  rem_in;
        logic [RAD_W-1:0]  rem_out;
        logic [ROOT_W-1:0] root_in;
        logic [ROOT_W-1:0] root_out;

        if (s == 0) begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
        end else begin : g_later
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        // Try each root bit: keep it when the remainder covers 2*r*2^k + 4^k.
        always_comb begin
            logic [RAD_W+1:0]  rem_v;
            logic [RAD_W+1:0]  trial;
            logic [ROOT_W-1:0] root_v;
            int                k;
            rem_v  = (RAD_W+2)'(rem_in);
            root_v = root_in;
            for (int t = 0; t < SQRT_STEPS; t++) begin
                k     = ROOT_W - 1 - s * SQRT_STEPS - t;
                trial = ((RAD_W+2)'(root_v) << (k + 1)) + ((RAD_W+2)'(1) << (2 * k));
                if (rem_v >= trial) begin
                    rem_v  = rem_v - trial;
                    root_v = root_v | (ROOT_W'(1) << k);
                end
            end
            rem_out  = rem_v[RAD_W-1:0];
            root_out = root_v;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_out;
                root_reg[s] <= root_out;
            end
        end
    end

    assign root = root_reg[SQRT_LAT-1];

endmodule

>>> hw/rtl/ppp_div.sv
// ----------------------------------------------------------------------------
// Point projection divider
// Pipelined restoring divider giving round(num / den), three bits per stage.
// ----------------------------------------------------------------------------
module ppp_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [ppp_pkg::NUM_W-1:0]   num,
    input  logic [ppp_pkg::ROOT_W-1:0]  den,
    output logic [ppp_pkg::QUO_W-1:0]   quo
);
    import ppp_pkg::*;

    localparam int REM_W = NUM_W + 1;

    logic [REM_W-1:0]  rem_reg [DIV_LAT];
    logic [QUO_W-1:0]  quo_reg [DIV_LAT];
    logic [ROOT_W-1:0] den_reg [DIV_LAT];

    for (genvar s = 0; s < DIV_LAT; s++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  rem_out;
        logic [QUO_W-1:0]  quo_in;
        logic [QUO_W-1:0]  quo_out;
        logic [ROOT_W-1:0] den_in;

        // The first stage adds half the divisor so the quotient rounds.
        if (s == 0) begin : g_first
            assign rem_in = REM_W'(num) + REM_W'(den >> 1);
            assign quo_in = '0;
            assign den_in = den;
        end else begin : g_later
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        always_comb begin
            logic [REM_W-1:0] rem_v;
            logic [REM_W-1:0] sub;
            logic [QUO_W-1:0] quo_v;
            int               k;
            rem_v = rem_in;
            quo_v = quo_in;
            for (int t = 0; t < DIV_STEPS; t++) begin
                k   = QUO_W - 1 - s * DIV_STEPS - t;
                sub = REM_W'(den_in) << k;
                if (rem_v >= sub) begin
                    rem_v = rem_v - sub;
                    quo_v = quo_v | (QUO_W'(1) << k);
                end
            end
            rem_out = rem_v;
            quo_out = quo_v;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_out;
                quo_reg[s] <= quo_out;
                den_reg[s] <= den_in;
            end
        end
    end

    assign quo = quo_reg[DIV_LAT-1];

endmodule

>>> hw/rtl/ppp_back.sv
// ----------------------------------------------------------------------------
// Point projection back end
// Rotates into the primitive frame, clamps or pulls back onto the surface,
// rotates back to the world frame and saturates. One request per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module ppp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ppp_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_pop,
    input  ppp_pkg::item_t              in_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ppp_pkg::DATA_W-1:0]  m_data    // qx, qy, qz, zero pad
);
    import ppp_pkg::*;

    localparam int TAIL_LAT = SQRT_LAT + DIV_LAT;

    typedef struct packed {
        logic                   sph;
        logic [2:0]             neg;
        logic [2:0]             use_q;
        logic [2:0][OFF_W-1:0]  keep;
    } tail_t;

    function automatic logic signed [LOC_W-1:0] round14(logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] tmp;
        tmp = (acc + ACC_W'(8192)) >>> 14;
        return tmp[LOC_W-1:0];
    endfunction

    function automatic logic signed [OFF_W-1:0] clamp_half(logic signed [LOC_W-1:0] c,
                                                           logic [COORD_W-1:0] h);
        logic signed [LOC_W-1:0] hs;
        logic signed [LOC_W-1:0] r;
        hs = LOC_W'(h);
        if (c > hs) begin
            r = hs;
        end else if (c < -hs) begin
            r = -hs;
        end else begin
            r = c;
        end
        return r[OFF_W-1:0];
    endfunction

    logic adv;
    logic m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;

    // Whole pipeline moves when the output slot is free or being taken.
    assign adv     = !m_valid_reg || m_ready;
    assign in_pop  = adv && in_valid;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- Stage 1: products for the transposed rotation.
    logic                     s1_valid_reg;
    logic [1:0]               s1_cls_reg;
    logic signed [OFF_W-1:0]  s1_d_reg    [3];
    logic signed [PROD_W-1:0] s1_prod_reg [3][3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_cls_reg <= in_item.cls;
            for (int i = 0; i < 3; i++) begin
                s1_d_reg[i] <= in_item.d[i];
                for (int j = 0; j < 3; j++) begin
                    s1_prod_reg[i][j] <= rot_at(cfg, j, i) * $signed(in_item.d[j]);
                end
            end
        end
    end

    // ---------------- Stage 2: local coordinates (sphere keeps the offset).
    logic                    s2_valid_reg;
    logic [1:0]              s2_cls_reg;
    logic signed [LOC_W-1:0] s2_c_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_cls_reg <= s1_cls_reg;
            for (int i = 0; i < 3; i++) begin
                if (s1_cls_reg == CLS_SPH) begin
                    s2_c_reg[i] <= LOC_W'(s1_d_reg[i]);
                end else begin
                    s2_c_reg[i] <= round14(ACC_W'(s1_prod_reg[i][0]) + ACC_W'(s1_prod_reg[i][1])
                                           + ACC_W'(s1_prod_reg[i][2]));
                end
            end
        end
    end

    // ---------------- Stage 3: magnitudes, squares and clamps.
    logic                    s3_valid_reg;
    logic [1:0]              s3_cls_reg;
    logic signed [LOC_W-1:0] s3_c_reg   [3];
    logic [LOC_W-1:0]        s3_mag_reg [3];
    logic [RAD_W-1:0]        s3_sq_reg  [3];
    logic signed [OFF_W-1:0] s3_clp_reg [3];
    logic [2*COORD_W-1:0]    s3_rad2_reg;

    always_ff @(posedge aclk) begin
        logic [LOC_W-1:0]   m;
        logic [COORD_W-1:0] h;
        if (adv) begin
            s3_cls_reg  <= s2_cls_reg;
            s3_rad2_reg <= size_at(cfg, 0) * size_at(cfg, 0);
            for (int i = 0; i < 3; i++) begin
                m = s2_c_reg[i][LOC_W-1] ? LOC_W'(~s2_c_reg[i] + 1'b1) : s2_c_reg[i];
                if (s2_cls_reg == CLS_CYL && i == 2) begin
                    h = size_at(cfg, 1) >> 1;
                end else begin
                    h = size_at(cfg, i) >> 1;
                end
                s3_c_reg[i]   <= s2_c_reg[i];
                s3_mag_reg[i] <= m;
                s3_sq_reg[i]  <= RAD_W'(m) * RAD_W'(m);
                s3_clp_reg[i] <= clamp_half(s2_c_reg[i], h);
            end
        end
    end

    // ---------------- Stage 4: radial test and pull-back numerators.
    logic             s4_valid_reg;
    logic [RAD_W-1:0] s4_r2_reg;
    logic [NUM_W-1:0] s4_num_reg [3];
    tail_t            s4_tail_reg;
    logic [RAD_W-1:0] r2;
    logic             pull;
    tail_t            tail_next;

    always_comb begin
        logic sph;
        logic cyl;
        sph = (s3_cls_reg == CLS_SPH);
        cyl = (s3_cls_reg == CLS_CYL);
        r2  = s3_sq_reg[0] + s3_sq_reg[1] + (sph ? s3_sq_reg[2] : '0);
        pull = (r2 > RAD_W'(s3_rad2_reg));
        tail_next.sph = sph;
        for (int i = 0; i < 3; i++) begin
            tail_next.neg[i]   = s3_c_reg[i][LOC_W-1];
            tail_next.use_q[i] = pull && (sph || (cyl && i < 2));
            if (sph || (cyl && i < 2)) begin
                tail_next.keep[i] = s3_c_reg[i][OFF_W-1:0];
            end else begin
                tail_next.keep[i] = s3_clp_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_r2_reg   <= r2;
            s4_tail_reg <= tail_next;
            for (int i = 0; i < 3; i++) begin
                s4_num_reg[i] <= NUM_W'(size_at(cfg, 0)) * NUM_W'(s3_mag_reg[i]);
            end
        end
    end

    // ---------------- Shared square root and per-lane dividers.
    logic [ROOT_W-1:0] root;
    logic [NUM_W-1:0]  num_pipe_reg  [SQRT_LAT][3];
    tail_t             tail_pipe_reg [TAIL_LAT];
    logic [TAIL_LAT-1:0] vpipe_reg;
    logic [QUO_W-1:0]  quo [3];

    ppp_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (adv),
        .radicand (s4_r2_reg),
        .root     (root)
    );

    for (genvar g = 0; g < 3; g++) begin : g_lane
        ppp_div u_div (
            .aclk (aclk),
            .en   (adv),
            .num  (num_pipe_reg[SQRT_LAT-1][g]),
            .den  (root),
            .quo  (quo[g])
        );
    end

    // Side data travels beside the shared units.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                num_pipe_reg[0][i] <= s4_num_reg[i];
            end
            for (int k = 1; k < SQRT_LAT; k++) begin
                for (int i = 0; i < 3; i++) begin
                    num_pipe_reg[k][i] <= num_pipe_reg[k-1][i];
                end
            end
            tail_pipe_reg[0] <= s4_tail_reg;
            for (int k = 1; k < TAIL_LAT; k++) begin
                tail_pipe_reg[k] <= tail_pipe_reg[k-1];
            end
        end
    end

    // ---------------- Final local point.
    logic                    sl_valid_reg;
    logic                    sl_sph_reg;
    logic signed [OFF_W-1:0] sl_loc_reg [3];

    always_ff @(posedge aclk) begin
        tail_t                   tl;
        logic signed [OFF_W-1:0] qs;
        tl = tail_pipe_reg[TAIL_LAT-1];
        if (adv) begin
            sl_sph_reg <= tl.sph;
            for (int i = 0; i < 3; i++) begin
                qs = OFF_W'(quo[i]);
                if (tl.use_q[i]) begin
                    sl_loc_reg[i] <= tl.neg[i] ? -qs : qs;
                end else begin
                    sl_loc_reg[i] <= tl.keep[i];
                end
            end
        end
    end

    // ---------------- Products for the rotation back to world.
    logic                     sp_valid_reg;
    logic                     sp_sph_reg;
    logic signed [OFF_W-1:0]  sp_loc_reg  [3];
    logic signed [PROD_W-1:0] sp_prod_reg [3][3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            sp_sph_reg <= sl_sph_reg;
            for (int i = 0; i < 3; i++) begin
                sp_loc_reg[i] <= sl_loc_reg[i];
                for (int j = 0; j < 3; j++) begin
                    sp_prod_reg[i][j] <= rot_at(cfg, i, j) * sl_loc_reg[j];
                end
            end
        end
    end

    // ---------------- World coordinate, saturation and output register.
    logic [DATA_W-1:0] out_next;

    always_comb begin
        logic signed [WORLD_W-1:0] w;
        logic signed [LOC_W-1:0]   r;
        out_next = '0;
        for (int i = 0; i < 3; i++) begin
            r = round14(ACC_W'(sp_prod_reg[i][0]) + ACC_W'(sp_prod_reg[i][1])
                        + ACC_W'(sp_prod_reg[i][2]));
            if (sp_sph_reg) begin
                w = WORLD_W'(sp_loc_reg[i]) + WORLD_W'(org_at(cfg, i));
            end else begin
                w = WORLD_W'(r) + WORLD_W'(org_at(cfg, i));
            end
            if (w > WORLD_W'(1048575)) begin
                out_next[COORD_W*i +: COORD_W] = 21'h0FFFFF;
            end else if (w < -WORLD_W'(1048576)) begin
                out_next[COORD_W*i +: COORD_W] = 21'h100000;
            end else begin
                out_next[COORD_W*i +: COORD_W] = w[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= out_next;
        end
    end

    // ---------------- Valid bits along the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            vpipe_reg    <= '0;
            sl_valid_reg <= 1'b0;
            sp_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            vpipe_reg    <= {vpipe_reg[TAIL_LAT-2:0], s4_valid_reg};
            sl_valid_reg <= vpipe_reg[TAIL_LAT-1];
            sp_valid_reg <= sl_valid_reg;
            m_valid_reg  <= sp_valid_reg;
        end
    end

endmodule

>>> hw/rtl/ppp_checker.sv
// ----------------------------------------------------------------------------
// Point projection port checker
// Port-level checks on reset behavior and the result stream.
// ----------------------------------------------------------------------------
module ppp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ppp_pkg::DATA_W-1:0]       m_tdata
);
    import ppp_pkg::*;

    // A result waiting on the sink stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // The padding bit of a result is always zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DATA_W-1] == 1'b0))
        else $error("result padding bit set");

    // Right after reset the block is empty and ready for requests.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("block not empty after reset");

endmodule

bind point_projection_onto_primitive_top ppp_checker u_ppp_checker (.*);
